>>> sv/positional_ordered_list_macros.svh
// Assertion helpers for the ordered list block.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define POL_CHECK(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Implication checked at every clock edge outside reset.
`define POL_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define POL_CHECK(lbl, clk, rst_n, cond, msg)
`define POL_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> sv/pol_pkg.sv
`default_nettype none

package pol_pkg;

    localparam int unsigned OPC_W   = 3;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [OPC_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_PREPEND  = 3'd1,
        OP_RM_FIRST = 3'd2,
        OP_RM_LAST  = 3'd3,
        OP_RM_AT    = 3'd4,
        OP_INS_AT   = 3'd5,
        OP_DUMP     = 3'd6
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> sv/pol_in_if.sv
`default_nettype none

interface pol_in_if;
    logic                      valid;
    logic                      ready;
    logic [pol_pkg::OPC_W-1:0] opcode;
    logic signed [pol_pkg::VAL_W-1:0] value;
    logic [pol_pkg::POS_W-1:0] position;

    modport source (output valid, output opcode, output value, output position, input ready);
    modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

`default_nettype wire

>>> sv/pol_out_if.sv
`default_nettype none

interface pol_out_if;
    logic                        valid;
    logic                        ready;
    logic [pol_pkg::STAT_W-1:0]  status;
    logic [pol_pkg::COUNT_W-1:0] count;
    logic signed [pol_pkg::VAL_W-1:0] element;
    logic                        element_valid;
    logic                        last;

    modport source (output valid, output status, output count, output element,
                    output element_valid, output last, input ready);
    modport sink   (input valid, input status, input count, input element,
                    input element_valid, input last, output ready);
endinterface

`default_nettype wire

>>> sv/positional_ordered_list.sv
// Edits: each shifted element takes a memory read, then a write; m = elements
//   shifted (insert at index k of n: m = n-k; remove at k: m = n-k-1); a refused
//   edit or an empty dump goes straight to the result. No new request until it is loaded.
// Dump of n: each element takes a memory read, then an output load; no new
//   request until the last is loaded. An output stall holds either sequence.
// Reset (synchronous, active low): count cleared, output empty; cells undefined.
`default_nettype none

`include "positional_ordered_list_macros.svh"

module positional_ordered_list #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pol_in_if.sink     i_req,
    pol_out_if.source  o_res
);

    localparam int unsigned IW    = $clog2(CAPACITY);
    localparam int unsigned HW    = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = pol_pkg::POS_W + 1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_RD   = 8'b0000_0010,
        S_UP_WR   = 8'b0000_0100,
        S_DN_RD   = 8'b0000_1000,
        S_DN_WR   = 8'b0001_0000,
        S_DUMP_RD = 8'b0010_0000,
        S_DUMP_WR = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state                       r_state, n_state;
    logic [HW-1:0]                r_held, n_held;
    logic [IW-1:0]                r_idx, n_idx;
    logic [IW-1:0]                r_tgt, n_tgt;
    logic [pol_pkg::VAL_W-1:0]    r_val, n_val;
    pol_pkg::t_status             r_stat, n_stat;

    logic                         r_ov, n_ov;
    pol_pkg::t_status             r_o_stat, n_o_stat;
    logic [pol_pkg::COUNT_W-1:0]  r_o_count, n_o_count;
    logic [pol_pkg::VAL_W-1:0]    r_o_elem, n_o_elem;
    logic                         r_o_ev, n_o_ev;
    logic                         r_o_last, n_o_last;

    logic                         mem_we, mem_re;
    logic [IW-1:0]                mem_waddr, mem_raddr;
    logic [pol_pkg::VAL_W-1:0]    mem_wdata, mem_rdata;

    logic                         out_free, full, empty, idx_is_tail;
    logic [CMP_W-1:0]             pos_ext, held_ext;
    logic [IW-1:0]                pos_idx;

    pol_mem #(.DEPTH(CAPACITY)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free    = !r_ov || o_res.ready;
    assign full        = (r_held == HW'(CAPACITY));
    assign empty       = (r_held == '0);
    assign pos_ext     = CMP_W'(i_req.position);
    assign held_ext    = CMP_W'(r_held);
    assign pos_idx     = IW'(i_req.position - pol_pkg::POS_W'(1));
    assign idx_is_tail = ((HW'(r_idx) + HW'(1)) == r_held);

    assign i_req.ready = (r_state == S_IDLE);

    assign o_res.valid         = r_ov;
    assign o_res.status        = r_o_stat;
    assign o_res.count         = r_o_count;
    assign o_res.element       = r_o_elem;
    assign o_res.element_valid = r_o_ev;
    assign o_res.last          = r_o_last;

    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_idx     = r_idx;
        n_tgt     = r_tgt;
        n_val     = r_val;
        n_stat    = r_stat;
        n_ov      = r_ov && !o_res.ready;
        n_o_stat  = r_o_stat;
        n_o_count = r_o_count;
        n_o_elem  = r_o_elem;
        n_o_ev    = r_o_ev;
        n_o_last  = r_o_last;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_val  = i_req.value;
                    n_stat = pol_pkg::ST_DONE;
                    n_idx  = IW'(r_held);
                    case (i_req.opcode)
                        pol_pkg::OP_APPEND: begin
                            n_tgt = IW'(r_held);
                            if (full) begin
                                n_stat  = pol_pkg::ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_UP_RD;
                            end
                        end
                        pol_pkg::OP_PREPEND: begin
                            n_tgt = '0;
                            if (full) begin
                                n_stat  = pol_pkg::ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_UP_RD;
                            end
                        end
                        pol_pkg::OP_RM_FIRST: begin
                            n_idx = '0;
                            if (empty) begin
                                n_stat  = pol_pkg::ST_IGNORED;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_DN_RD;
                            end
                        end
                        pol_pkg::OP_RM_LAST: begin
                            n_idx = IW'(r_held - HW'(1));
                            if (empty) begin
                                n_stat  = pol_pkg::ST_IGNORED;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_DN_RD;
                            end
                        end
                        pol_pkg::OP_RM_AT: begin
                            n_idx = pos_idx;
                            if (pos_ext == '0 || pos_ext > held_ext) begin
                                n_stat  = pol_pkg::ST_IGNORED;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_DN_RD;
                            end
                        end
                        pol_pkg::OP_INS_AT: begin
                            n_tgt = pos_idx;
                            // position check takes precedence over full
                            if (pos_ext == '0 || pos_ext > held_ext + CMP_W'(1)) begin
                                n_stat  = pol_pkg::ST_IGNORED;
                                n_state = S_DONE;
                            end else if (full) begin
                                n_stat  = pol_pkg::ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_UP_RD;
                            end
                        end
                        pol_pkg::OP_DUMP: begin
                            n_idx = '0;
                            if (empty) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_DUMP_RD;
                            end
                        end
                        default: begin
                            n_stat  = pol_pkg::ST_IGNORED;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_idx == r_tgt) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_tgt;
                    mem_wdata = r_val;
                    n_held    = r_held + HW'(1);
                    n_state   = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx - IW'(1);
                    n_state   = S_UP_WR;
                end
            end
            S_UP_WR: begin
                mem_we  = 1'b1;
                n_idx   = r_idx - IW'(1);
                n_state = S_UP_RD;
            end
            S_DN_RD: begin
                if (idx_is_tail) begin
                    n_held  = r_held - HW'(1);
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx + IW'(1);
                    n_state   = S_DN_WR;
                end
            end
            S_DN_WR: begin
                mem_we  = 1'b1;
                n_idx   = r_idx + IW'(1);
                n_state = S_DN_RD;
            end
            S_DUMP_RD: begin
                mem_re  = 1'b1;
                n_state = S_DUMP_WR;
            end
            S_DUMP_WR: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_o_stat  = pol_pkg::ST_DONE;
                    n_o_count = pol_pkg::COUNT_W'(r_held);
                    n_o_elem  = mem_rdata;
                    n_o_ev    = 1'b1;
                    n_o_last  = idx_is_tail;
                    if (idx_is_tail) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_DUMP_RD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_o_stat  = r_stat;
                    n_o_count = pol_pkg::COUNT_W'(r_held);
                    n_o_elem  = '0;
                    n_o_ev    = 1'b0;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_tgt     <= n_tgt;
        r_val     <= n_val;
        r_stat    <= n_stat;
        r_o_stat  <= n_o_stat;
        r_o_count <= n_o_count;
        r_o_elem  <= n_o_elem;
        r_o_ev    <= n_o_ev;
        r_o_last  <= n_o_last;
    end

    `POL_CHECK(a_held_bound, i_clk, i_rst_n, r_held <= HW'(CAPACITY), "count above capacity")
    `POL_IMPLY(a_up_above_tgt, i_clk, i_rst_n, r_state == S_UP_WR, r_idx > r_tgt, "shift up past target")
    `POL_IMPLY(a_dn_in_list, i_clk, i_rst_n, r_state == S_DN_WR, (HW'(r_idx) + HW'(1)) < r_held, "shift down past tail")
    `POL_IMPLY(a_held_commit, i_clk, i_rst_n, $past(i_rst_n) && (r_held != $past(r_held)), $past(r_state == S_UP_RD) || $past(r_state == S_DN_RD), "count changed outside commit")

endmodule

`default_nettype wire

>>> sv/pol_mem.sv
`default_nettype none

module pol_mem #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  wire logic [pol_pkg::VAL_W-1:0]       i_wdata,
    input  wire logic                            i_re,
    input  wire logic [$clog2(DEPTH)-1:0]        i_raddr,
    output logic      [pol_pkg::VAL_W-1:0]       o_rdata
);

    logic [pol_pkg::VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
